FILE: sv/assert_macros.svh
// Assertion macros shared by the voice codec degrader RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset
`define VCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds outside reset
`define VCD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: sv/vcd_pkg.sv
// Package: types, constants and saturation helpers of the voice codec degrader
`default_nettype none
package vcd_pkg;

  localparam int MAX_CH   = 2;
  localparam int SMP_W    = 16;
  localparam int CH_W     = 2;
  localparam int CH_IDX_W = 1;
  localparam int STG_W    = 2;
  localparam int BQ_N     = 4 * MAX_CH;
  localparam int COEF_W   = 26;
  localparam int Z_W      = 40;
  localparam int ENV_W    = 24;
  localparam int PH_W     = 25;
  localparam int S_W      = 40;
  localparam int MA_W     = 38;
  localparam int MB_W     = 27;
  localparam int MP_W     = MA_W + MB_W;
  localparam int DNUM_W   = 43;
  localparam int DDEN_W   = 41;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 26;

  localparam logic [ENV_W-1:0] ENV_MAX   = '1;
  localparam logic [ENV_W-1:0] ENV_RESET = 24'd1678;
  localparam logic [ENV_W-1:0] ENV_FLOOR = 24'd168;
  localparam logic [MB_W-1:0]  ATTACK_Q24  = 27'd345910;
  localparam logic [MB_W-1:0]  RELEASE_Q24 = 27'd2330;
  localparam logic [MB_W-1:0]  LCG_A = 27'd1664525;
  localparam logic [31:0]      LCG_C = 32'd1013904223;
  localparam logic [31:0]      SEED_RESET = 32'd1;
  localparam logic [PH_W-1:0]  PH_ONE = 25'd16777216;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0, REG_B1, REG_A1, REG_A2, REG_HOLD_STEP, REG_QUANT_SCALE, REG_NOISE_GAIN,
    REG_ACTIVE
  } reg_idx_t;

  typedef logic signed [SMP_W-1:0] smp_t;
  typedef smp_t [MAX_CH-1:0] smp_vec_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    logic [PH_W-1:0]          hold_step;
    logic [15:0]              quant_scale;
    logic [14:0]              noise_gain;
    logic [1:0]               active;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_ENV_MUL, ST_ENV_UPD, ST_S_MUL, ST_S_SET, ST_CH,
    ST_BQ0, ST_BQ1, ST_BQ2, ST_BQ3, ST_BQ4,
    ST_RS_PH, ST_RS_MUL, ST_RS_OUT,
    ST_Q_DIV, ST_Q_WAIT, ST_Q_HI, ST_Q_RND,
    ST_D_MUL, ST_D_SEED, ST_D_UG, ST_D_ENV, ST_D_ADD,
    ST_DONE
  } state_t;

  function automatic smp_t sat_smp(input logic signed [47:0] v);
    if (v > 48'sd32767) return 16'sh7fff;
    if (v < -48'sd32768) return 16'sh8000;
    return v[SMP_W-1:0];
  endfunction

  function automatic logic signed [Z_W-1:0] sat_z(input logic signed [47:0] v);
    if (v > 48'sh007f_ffff_ffff) return 40'sh7f_ffff_ffff;
    if (v < -48'sh0080_0000_0000) return 40'sh80_0000_0000;
    return v[Z_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: sv/vcd_mul.sv
// Shared signed multiplier with registered product
`default_nettype none
module vcd_mul (
  input  logic                             clk,
  input  logic signed [vcd_pkg::MA_W-1:0]  a,
  input  logic signed [vcd_pkg::MB_W-1:0]  b,
  output logic signed [vcd_pkg::MP_W-1:0]  p
);
  import vcd_pkg::*;

  always_ff @(posedge clk) begin
    p <= MP_W'(a) * MP_W'(b);
  end
endmodule
`default_nettype wire

FILE: sv/vcd_div.sv
// Bit-serial signed floor divider, one quotient bit per cycle
`default_nettype none
module vcd_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [vcd_pkg::DNUM_W-1:0]  num,
  input  logic [vcd_pkg::DDEN_W-1:0]         den,
  output logic                               done,
  output logic signed [vcd_pkg::MA_W-1:0]    quo
);
  import vcd_pkg::*;

  localparam int MAG_W = DNUM_W - 1;

  logic             busy;
  logic [5:0]       cnt;
  logic             neg;
  logic [MAG_W-1:0] mag;
  logic [MAG_W-1:0] rem;
  logic [DDEN_W-1:0] dreg;
  logic [MAG_W-1:0] trial;
  logic             fits;
  logic [DNUM_W-1:0] num_abs;

  assign num_abs = num[DNUM_W-1] ? DNUM_W'(-num) : DNUM_W'(num);
  assign trial   = {rem[MAG_W-2:0], mag[MAG_W-1]};
  assign fits    = trial >= MAG_W'(dreg);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        neg  <= num[DNUM_W-1];
        mag  <= num_abs[MAG_W-1:0];
        rem  <= '0;
        dreg <= den;
      end else if (busy) begin
        rem <= fits ? trial - MAG_W'(dreg) : trial;
        mag <= {mag[MAG_W-2:0], fits};
        cnt <= cnt + 6'd1;
        if (cnt == 6'(MAG_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (neg) quo = -MA_W'($signed({1'b0, mag})) - MA_W'(rem != '0);
    else     quo = MA_W'($signed({1'b0, mag}));
  end
endmodule
`default_nettype wire

FILE: sv/vcd_core.sv
// Sequencer and state of the degrader around the shared multiplier and divider
`default_nettype none
module vcd_core (
  input  logic              clk,
  input  logic              rst,
  input  vcd_pkg::cfg_t     cfg,
  input  logic              start,
  input  vcd_pkg::smp_vec_t in_smp,
  output logic              idle,
  output logic              res_valid,
  input  logic              res_ready,
  output vcd_pkg::smp_vec_t res_smp
);
  import vcd_pkg::*;

  state_t state, state_next;

  logic [CH_W-1:0]  ch;
  logic [STG_W-1:0] stage;
  smp_vec_t         smp;
  logic [ENV_W-1:0] env;
  logic [31:0]      seed;
  logic [S_W-1:0]   s_reg;
  smp_t             x, y, held, q;
  logic signed [63:0] t0, t1;
  logic signed [Z_W-1:0] z1 [BQ_N];
  logic signed [Z_W-1:0] z2 [BQ_N];
  smp_t             cur [MAX_CH];
  smp_t             nxt [MAX_CH];
  logic [PH_W-1:0]  phase [MAX_CH];

  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [MP_W-1:0] prod;
  logic                   div_start, div_done;
  logic signed [MA_W-1:0] div_quo;
  logic signed [MA_W-1:0] nq;

  logic [CH_W-1:0]  nch;
  logic [SMP_W:0]   pmax;
  logic [ENV_W-1:0] p24;
  logic signed [ENV_W+1:0] env_diff;
  logic signed [26:0] env_sum;
  logic [ENV_W-1:0] envf;
  logic [16:0]      qs_eff;
  logic [CH_IDX_W-1:0] ci;
  logic [2:0]       idx;
  logic             bypass;
  logic [PH_W-1:0]  ph_sum;
  logic signed [43:0] acc;
  logic signed [65:0] ns;
  smp_t             q_rnd;
  logic signed [DNUM_W-1:0] div_num;

  assign nch    = (cfg.active > CH_W'(MAX_CH)) ? CH_W'(MAX_CH) : cfg.active;
  assign ci     = ch[CH_IDX_W-1:0];
  assign idx    = {ci, stage};
  assign bypass = cfg.hold_step >= PH_ONE;
  assign envf   = (env > ENV_FLOOR) ? env : ENV_FLOOR;
  assign qs_eff = (cfg.quant_scale == '0) ? 17'd1 : {1'b0, cfg.quant_scale};
  assign ph_sum = phase[ci] + cfg.hold_step;

  always_comb begin
    logic [SMP_W:0] ext;
    logic [SMP_W:0] av;
    pmax = '0;
    for (int i = 0; i < MAX_CH; i++) begin
      ext = {smp[i][SMP_W-1], smp[i]};
      av  = smp[i][SMP_W-1] ? (~ext + 1'b1) : ext;
      if ((CH_W'(i) < nch) && (av > pmax)) pmax = av;
    end
  end

  assign p24      = pmax[SMP_W-1] ? ENV_MAX : {pmax[SMP_W-2:0], 9'd0};
  assign env_diff = $signed({2'b00, p24}) - $signed({2'b00, env});
  assign env_sum  = $signed({3'b000, env}) + 27'(prod >>> 24);
  assign acc      = 44'(prod) + 44'(z1[idx]);
  assign ns       = $signed({prod[45:0], 20'd0}) + 66'(t0);
  assign q_rnd    = sat_smp(48'((ns + 66'sd16777216) >>> 25));
  assign div_num  = $signed({held, 26'd0}) + $signed({3'b000, s_reg});

  vcd_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

  vcd_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num),
    .den({s_reg, 1'b0}), .done(div_done), .quo(div_quo)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (start) state_next = ST_ENV_MUL;
      ST_ENV_MUL: state_next = ST_ENV_UPD;
      ST_ENV_UPD: state_next = ST_S_MUL;
      ST_S_MUL:   state_next = ST_S_SET;
      ST_S_SET:   state_next = ST_CH;
      ST_CH: begin
        if (ch == CH_W'(MAX_CH)) state_next = ST_DONE;
        else if (ch >= nch)      state_next = ST_CH;
        else                     state_next = ST_BQ0;
      end
      ST_BQ0:     state_next = ST_BQ1;
      ST_BQ1:     state_next = ST_BQ2;
      ST_BQ2:     state_next = ST_BQ3;
      ST_BQ3:     state_next = ST_BQ4;
      ST_BQ4: begin
        if (stage == 2'd1)      state_next = ST_RS_PH;
        else if (stage == 2'd3) state_next = ST_CH;
        else                    state_next = ST_BQ0;
      end
      ST_RS_PH:   state_next = bypass ? ST_Q_DIV : ST_RS_MUL;
      ST_RS_MUL:  state_next = ST_RS_OUT;
      ST_RS_OUT:  state_next = ST_Q_DIV;
      ST_Q_DIV:   state_next = ST_Q_WAIT;
      ST_Q_WAIT:  if (div_done) state_next = ST_Q_HI;
      ST_Q_HI:    state_next = ST_Q_RND;
      ST_Q_RND:   state_next = (cfg.noise_gain != '0) ? ST_D_MUL : ST_BQ0;
      ST_D_MUL:   state_next = ST_D_SEED;
      ST_D_SEED:  state_next = ST_D_UG;
      ST_D_UG:    state_next = ST_D_ENV;
      ST_D_ENV:   state_next = ST_D_ADD;
      ST_D_ADD:   state_next = ST_BQ0;
      ST_DONE:    if (res_ready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    idle      = (state == ST_IDLE);
    res_valid = (state == ST_DONE);
    unique case (state)
      ST_ENV_MUL: begin
        mul_a = MA_W'(env_diff);
        mul_b = (p24 > env) ? ATTACK_Q24 : RELEASE_Q24;
      end
      ST_S_MUL: begin
        mul_a = $signed({14'd0, envf});
        mul_b = $signed({10'd0, qs_eff});
      end
      ST_BQ0: begin
        mul_a = MA_W'(cfg.b0);
        mul_b = MB_W'(x);
      end
      ST_BQ1: begin
        mul_a = MA_W'(cfg.b1);
        mul_b = MB_W'(x);
      end
      ST_BQ2: begin
        mul_a = MA_W'(cfg.a1);
        mul_b = MB_W'(y);
      end
      ST_BQ3: begin
        mul_a = MA_W'(cfg.a2);
        mul_b = MB_W'(y);
      end
      ST_RS_MUL: begin
        mul_a = MA_W'(17'(nxt[ci]) - 17'(cur[ci]));
        mul_b = $signed({2'b00, phase[ci]});
      end
      ST_Q_DIV: div_start = 1'b1;
      ST_Q_WAIT: begin
        mul_a = div_quo;
        mul_b = $signed({7'd0, s_reg[19:0]});
      end
      ST_Q_HI: begin
        mul_a = nq;
        mul_b = $signed({7'd0, s_reg[39:20]});
      end
      ST_D_MUL: begin
        mul_a = $signed({6'd0, seed});
        mul_b = LCG_A;
      end
      ST_D_UG: begin
        mul_a = MA_W'($signed({~seed[31], seed[30:9]}));
        mul_b = $signed({12'd0, cfg.noise_gain});
      end
      ST_D_ENV: begin
        mul_a = prod[MA_W-1:0];
        mul_b = $signed({3'd0, env});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ch    <= '0;
      stage <= '0;
      env   <= ENV_RESET;
      seed  <= SEED_RESET;
      for (int i = 0; i < BQ_N; i++) begin
        z1[i] <= '0;
        z2[i] <= '0;
      end
      for (int i = 0; i < MAX_CH; i++) begin
        cur[i]   <= '0;
        nxt[i]   <= '0;
        phase[i] <= '0;
      end
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: if (start) begin
          smp <= in_smp;
          ch  <= '0;
        end
        ST_ENV_UPD: begin
          if (env_sum < 0)                        env <= '0;
          else if (env_sum > $signed({3'b000, ENV_MAX})) env <= ENV_MAX;
          else                                    env <= env_sum[ENV_W-1:0];
        end
        ST_S_SET: s_reg <= prod[S_W-1:0];
        ST_CH: if (ch != CH_W'(MAX_CH)) begin
          if (ch >= nch) begin
            res_smp[ci] <= smp[ci];
            ch <= ch + 1'b1;
          end else begin
            stage <= '0;
            x     <= smp[ci];
          end
        end
        ST_BQ1: begin
          y  <= sat_smp(48'((acc + 44'sd2097152) >>> 22));
          t0 <= 64'(prod);
        end
        ST_BQ2: t1 <= 64'(prod);
        ST_BQ3: z1[idx] <= sat_z(48'(t1) - 48'(prod) + 48'(z2[idx]));
        ST_BQ4: begin
          z2[idx] <= sat_z(48'(t0) - 48'(prod));
          x <= y;
          if (stage == 2'd3) begin
            res_smp[ci] <= y;
            ch <= ch + 1'b1;
          end else begin
            stage <= stage + 1'b1;
          end
        end
        ST_RS_PH: begin
          if (bypass) begin
            held <= x;
          end else if (ph_sum[PH_W-1]) begin
            phase[ci] <= {1'b0, ph_sum[PH_W-2:0]};
            cur[ci]   <= nxt[ci];
            nxt[ci]   <= x;
          end else begin
            phase[ci] <= ph_sum;
          end
        end
        ST_RS_OUT: held <= cur[ci] + 16'(prod >>> 24);
        ST_Q_WAIT: if (div_done) nq <= div_quo;
        ST_Q_HI:   t0 <= 64'(prod);
        ST_Q_RND: begin
          q <= q_rnd;
          x <= q_rnd;
        end
        ST_D_SEED: seed <= prod[31:0] + LCG_C;
        ST_D_ADD:  x <= sat_smp(48'(q) + 48'(prod >>> 56));
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: sv/voice_codec_degrader.sv
// Top level: stream ports, configuration registers and output register
//
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tdata {sample_1, sample_0}, tlast
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata {out_1, out_0}, tlast
// cfg       in         cfg_valid/cfg_ready           cfg_index, cfg_data
//
// A frame runs through accept, envelope update, step setup and dispatch, then per active
// channel through the biquad cascade, with the resampler (bypassed when hold_step reaches
// PH_ONE), the quantizer around the bit-serial divider and the dither (when noise_gain is
// nonzero) between its halves, and ends with the result. Reset clears all filter and
// resampler state and loads the envelope and noise seed with their reset values. A stalled
// output holds the core in its final state; the input is taken only while the core is idle.
`default_nettype none
module voice_codec_degrader (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // sample_0 [15:0], sample_1 [31:16]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // out_0 [15:0], out_1 [31:16]
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [vcd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vcd_pkg::CFG_DAT_W-1:0] cfg_data
);
  import vcd_pkg::*;
  `include "assert_macros.svh"

  cfg_t     cfg;
  logic     core_idle, res_valid, res_ready, in_xfer;
  logic     last_hold;
  smp_vec_t in_smp, res_smp;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = core_idle;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign res_ready     = !m_axis_tvalid || m_axis_tready;
  assign in_smp[0]     = s_axis_tdata[15:0];
  assign in_smp[1]     = s_axis_tdata[31:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.b0          <= '0;
      cfg.b1          <= '0;
      cfg.a1          <= '0;
      cfg.a2          <= '0;
      cfg.hold_step   <= PH_ONE;
      cfg.quant_scale <= 16'd128;
      cfg.noise_gain  <= '0;
      cfg.active      <= 2'd2;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_B0:          cfg.b0          <= cfg_data;
        REG_B1:          cfg.b1          <= cfg_data;
        REG_A1:          cfg.a1          <= cfg_data;
        REG_A2:          cfg.a2          <= cfg_data;
        REG_HOLD_STEP:   cfg.hold_step   <= cfg_data[PH_W-1:0];
        REG_QUANT_SCALE: cfg.quant_scale <= cfg_data[15:0];
        REG_NOISE_GAIN:  cfg.noise_gain  <= cfg_data[14:0];
        REG_ACTIVE:      cfg.active      <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  vcd_core u_core (
    .clk(clk), .rst(rst), .cfg(cfg), .start(in_xfer), .in_smp(in_smp),
    .idle(core_idle), .res_valid(res_valid), .res_ready(res_ready), .res_smp(res_smp)
  );

  always_ff @(posedge clk) begin
    if (in_xfer) last_hold <= s_axis_tlast;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
      if (res_valid) begin
        m_axis_tdata <= {res_smp[1], res_smp[0]};
        m_axis_tlast <= last_hold;
      end
    end
  end

  `VCD_ASSERT(a_busy_after_take, in_xfer |=> !s_axis_tready, "input taken while busy")
  `VCD_ASSERT(a_result_lands, (res_valid && res_ready) |=> m_axis_tvalid, "result lost")
  `VCD_NEVER(a_idle_and_done, core_idle && res_valid, "core idle with pending result")
endmodule
`default_nettype wire
